// ===== rtl/ils_pkg.sv =====
// Shared package for the indexed list store: beat formats, request codes and
// the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package ils_pkg;

    localparam int REQ_W  = 3;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 7;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd4;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value_in;
    } t_in_beat;

    typedef struct packed {
        logic [DATA_W-1:0] value_out;
        logic              status;
        logic [CNT_W-1:0]  count;
    } t_out_beat;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // latch the accepted request
        logic setup;    // check the request and arm the shift counters
        logic shift;    // move one entry per cycle
        logic commit;   // final write, count update or target read
        logic capture;  // load the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic ok;          // request is legal (valid during setup)
        logic shift_done;  // no moves left and nothing in flight
    } t_stat;

endpackage

// ===== rtl/indexed_list_store_unit.sv =====
// Indexed list store: a request is decoded and, if legal, shifts m entries (insert count -
// position, remove count - position - 1, none for a read or replace) and commits; a rejected
// request goes straight to the result step. The shift moves one entry per cycle through the
// entry memory. One request is in flight, so a new beat is accepted only after the previous
// result has been loaded into the output register. Synchronous active-low reset clears count
// and control, sets capacity to 64, keeps storage.
`timescale 1ns / 1ps

module indexed_list_store_unit #(
    parameter int MAX_ENTRIES = ils_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = ils_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel.
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  ils_pkg::t_in_beat         i_in_data,
    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output ils_pkg::t_out_beat        o_out_data,
    // Capacity register write channel.
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ils_pkg::CAP_W-1:0] i_cfg_data
);

    // The controller sequences each request through decode, shift, commit and
    // result steps (rejects skip shift and commit); the datapath owns all storage
    // and reports only whether the request is legal and whether the shift drained.
    ils_pkg::t_cmd  cmd;
    ils_pkg::t_stat stat;

    // The capacity register is a plain flop and can take a beat every cycle.
    // Writes are only expected while no request is being worked on.
    assign o_cfg_ready = 1'b1;

    ils_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Insert moves entries from the tail down to the target, remove from the
    // target up to the tail. Each word is written in the cycle after it is read,
    // so the shift step drains the final write and sees the engine idle before
    // it ends.
    ils_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ===== rtl/ils_ctrl.sv =====
// Controller for the indexed list store: one-hot sequencer and output valid.
// Depends on ils_pkg for the command and status bundles.
`timescale 1ns / 1ps

module ils_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output ils_pkg::t_cmd o_cmd,
    input  ils_pkg::t_stat i_stat
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_COMMIT = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.setup = 1'b1;
                n_state     = i_stat.ok ? S_SHIFT : S_RESULT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/ils_dp.sv =====
// Datapath for the indexed list store: entry memory, count, capacity register,
// shift address counters and the output register. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_dp #(
    parameter int MAX_ENTRIES = ils_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = ils_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ils_pkg::t_cmd                 i_cmd,
    output ils_pkg::t_stat                o_stat,
    input  ils_pkg::t_in_beat             i_in_data,
    output ils_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_valid,
    input  logic [ils_pkg::CAP_W-1:0]     i_cfg_data
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = ils_pkg::CNT_W;
    localparam int POS_W  = ils_pkg::POS_W;

    logic [VALUE_BITS-1:0] mem [MAX_ENTRIES];

    // Latched request.
    logic [ils_pkg::REQ_W-1:0] r_req, n_req;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [VALUE_BITS-1:0]     r_val, n_val;
    logic                      r_ok, n_ok;

    // Shift engine.
    logic [CNT_W-1:0]  r_rd_left, n_rd_left;
    logic              r_pend, n_pend;
    logic              r_dir_down, n_dir_down;
    logic [ADDR_W-1:0] r_src, n_src;
    logic [ADDR_W-1:0] r_dst, n_dst;

    logic [CNT_W-1:0]          r_count, n_count;
    logic [ils_pkg::CAP_W-1:0] r_cap, n_cap;
    ils_pkg::t_out_beat        r_out, n_out;
    logic [VALUE_BITS-1:0]     r_rdata;

    // Request check.
    logic              ok;
    logic [CNT_W-1:0]  moves;
    logic [ADDR_W-1:0] first_src, first_dst;
    logic              dir_down;

    // Memory port controls.
    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [VALUE_BITS-1:0] wr_data;

    always_comb begin
        ok        = 1'b0;
        moves     = '0;
        first_src = ADDR_W'(r_pos + POS_W'(1));
        first_dst = ADDR_W'(r_pos);
        dir_down  = 1'b0;
        case (r_req)
            ils_pkg::REQ_INSERT: begin
                ok = (r_pos <= POS_W'(r_count)) && (r_count < r_cap)
                     && (int'(r_count) < MAX_ENTRIES);
                moves     = CNT_W'(r_count - CNT_W'(r_pos));
                first_src = ADDR_W'(r_count - CNT_W'(1));
                first_dst = ADDR_W'(r_count);
                dir_down  = 1'b1;
            end
            ils_pkg::REQ_READ, ils_pkg::REQ_REPLACE: begin
                ok = (CNT_W'(r_pos) < r_count);
            end
            ils_pkg::REQ_REMOVE: begin
                ok    = (CNT_W'(r_pos) < r_count);
                moves = CNT_W'(r_count - CNT_W'(r_pos) - CNT_W'(1));
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign o_stat.ok         = ok;
    assign o_stat.shift_done = (r_rd_left == '0) && !r_pend;

    // A shift cycle writes the word read in the previous cycle and reads the next
    // source; reads always run at least one entry ahead of the writes.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_dst;
        wr_data = r_rdata;
        rd_en   = 1'b0;
        rd_addr = r_src;
        if (i_cmd.shift) begin
            wr_en = r_pend;
            rd_en = (r_rd_left != '0);
        end
        if (i_cmd.commit && r_ok) begin
            if (r_req == ils_pkg::REQ_INSERT || r_req == ils_pkg::REQ_REPLACE) begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(r_pos);
                wr_data = r_val;
            end
            if (r_req == ils_pkg::REQ_READ) begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(r_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_comb begin
        n_req      = r_req;
        n_pos      = r_pos;
        n_val      = r_val;
        n_ok       = r_ok;
        n_rd_left  = r_rd_left;
        n_pend     = r_pend;
        n_dir_down = r_dir_down;
        n_src      = r_src;
        n_dst      = r_dst;
        n_count    = r_count;
        n_cap      = r_cap;
        n_out      = r_out;

        // Append is an insert at the current end of the list.
        if (i_cmd.load) begin
            n_val = VALUE_BITS'(i_in_data.value_in);
            if (i_in_data.req_type == ils_pkg::REQ_APPEND) begin
                n_req = ils_pkg::REQ_INSERT;
                n_pos = POS_W'(r_count);
            end else begin
                n_req = i_in_data.req_type;
                n_pos = i_in_data.position;
            end
        end

        if (i_cmd.setup) begin
            n_ok       = ok;
            n_rd_left  = ok ? moves : '0;
            n_pend     = 1'b0;
            n_dir_down = dir_down;
            n_src      = first_src;
            n_dst      = first_dst;
        end

        if (i_cmd.shift) begin
            if (r_rd_left != '0) begin
                n_rd_left = r_rd_left - CNT_W'(1);
                n_pend    = 1'b1;
                n_src     = r_dir_down ? r_src - ADDR_W'(1) : r_src + ADDR_W'(1);
            end else begin
                n_pend = 1'b0;
            end
            if (r_pend) begin
                n_dst = r_dir_down ? r_dst - ADDR_W'(1) : r_dst + ADDR_W'(1);
            end
        end

        if (i_cmd.commit && r_ok) begin
            if (r_req == ils_pkg::REQ_INSERT) begin
                n_count = r_count + CNT_W'(1);
            end else if (r_req == ils_pkg::REQ_REMOVE) begin
                n_count = r_count - CNT_W'(1);
            end
        end

        if (i_cmd.capture) begin
            n_out.value_out = (r_ok && r_req == ils_pkg::REQ_READ)
                              ? ils_pkg::DATA_W'(r_rdata) : '0;
            n_out.status    = r_ok ? ils_pkg::STATUS_DONE : ils_pkg::STATUS_REJECTED;
            n_out.count     = r_count;
        end

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cap     <= ils_pkg::CAP_RESET;
            r_rd_left <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_cap     <= n_cap;
            r_rd_left <= n_rd_left;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_ok       <= n_ok;
        r_dir_down <= n_dir_down;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_out      <= n_out;
    end

    assign o_out_data = r_out;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for indexed_list_store_unit: directed and random list requests
// against a behavioral list predictor. Depends on rtl/ils_pkg.sv and the unit itself.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF    = 6;
    localparam int STUCK_LIMIT = 4000;
    localparam int POS_MAX     = (1 << ils_pkg::POS_W) - 1;
    localparam int CAP_MAX     = (1 << ils_pkg::CAP_W) - 1;
    localparam int IDX_W       = $clog2(ils_pkg::MAX_ENTRIES_DEF);

    // Request codes above REQ_REPLACE are undefined and must be rejected.
    localparam logic [ils_pkg::REQ_W-1:0] REQ_UNKNOWN_FIRST =
        ils_pkg::REQ_REPLACE + ils_pkg::REQ_W'(1);
    localparam logic [ils_pkg::REQ_W-1:0] REQ_UNKNOWN_LAST  = '1;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    ils_pkg::t_in_beat             i_in_data;
    logic                          o_out_valid;
    logic                          i_out_stall;
    ils_pkg::t_out_beat            o_out_data;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [ils_pkg::CAP_W-1:0]     i_cfg_data;

    // Shadow copy of the list, its length and the capacity register.
    logic [ils_pkg::DATA_W-1:0] shadow_list [ils_pkg::MAX_ENTRIES_DEF];
    int                         shadow_len;
    int                         shadow_cap;

    ils_pkg::t_out_beat predicted_replies [$];
    int                 mismatch_count;
    int                 gap_pct;
    int                 stuck_cycles;

    indexed_list_store_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Applies one request to the shadow list and returns the reply it should produce.
    function automatic ils_pkg::t_out_beat list_apply(input ils_pkg::t_in_beat req);
        ils_pkg::t_out_beat        reply;
        logic [ils_pkg::REQ_W-1:0] op;
        int                        pos;
        int                        limit;
        int                        k;
        reply        = '0;
        reply.status = ils_pkg::STATUS_REJECTED;
        limit        = (shadow_cap > ils_pkg::MAX_ENTRIES_DEF) ? ils_pkg::MAX_ENTRIES_DEF
                                                              : shadow_cap;
        op           = req.req_type;
        pos          = int'(req.position);
        // Append is an insert at the current end of the list.
        if (op == ils_pkg::REQ_APPEND) begin
            op  = ils_pkg::REQ_INSERT;
            pos = shadow_len;
        end
        case (op)
            ils_pkg::REQ_INSERT: begin
                if (pos <= shadow_len && shadow_len < limit) begin
                    for (k = shadow_len; k > pos; k--)
                        shadow_list[IDX_W'(k)] = shadow_list[IDX_W'(k - 1)];
                    shadow_list[IDX_W'(pos)] = req.value_in;
                    shadow_len++;
                    reply.status = ils_pkg::STATUS_DONE;
                end
            end
            ils_pkg::REQ_READ: begin
                if (pos < shadow_len) begin
                    reply.value_out = shadow_list[IDX_W'(pos)];
                    reply.status    = ils_pkg::STATUS_DONE;
                end
            end
            ils_pkg::REQ_REMOVE: begin
                if (pos < shadow_len) begin
                    for (k = pos; k + 1 < shadow_len; k++)
                        shadow_list[IDX_W'(k)] = shadow_list[IDX_W'(k + 1)];
                    shadow_len--;
                    reply.status = ils_pkg::STATUS_DONE;
                end
            end
            ils_pkg::REQ_REPLACE: begin
                if (pos < shadow_len) begin
                    shadow_list[IDX_W'(pos)] = req.value_in;
                    reply.status             = ils_pkg::STATUS_DONE;
                end
            end
            default: begin
                // Undefined codes leave the list untouched.
            end
        endcase
        reply.count = ils_pkg::CNT_W'(shadow_len);
        return reply;
    endfunction

    // Sends one request beat, holding it until accepted, then records its reply.
    task automatic send_request(input logic [ils_pkg::REQ_W-1:0] op, input int pos,
                                input logic [ils_pkg::DATA_W-1:0] val);
        ils_pkg::t_in_beat beat;
        beat.req_type = op;
        beat.position = ils_pkg::POS_W'(pos);
        beat.value_in = val;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted_replies.push_back(list_apply(beat));
    endtask

    // Stops sending and waits until every outstanding reply has been checked.
    task automatic wait_drained();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_capacity(input int cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ils_pkg::CAP_W'(cap);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_cap = cap & CAP_MAX;
    endtask

    // Random traffic. Most positions are legal for the current length so the
    // shifts really happen; a tenth are anywhere in the field's range.
    task automatic run_random_phase(input int n_items, input int grow_pct,
                                    input int shrink_pct, input int pause_pct);
        int                        pick;
        int                        pos;
        logic [ils_pkg::REQ_W-1:0] op;
        repeat (n_items) begin
            if ($urandom_range(99) < pause_pct)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < grow_pct)
                op = $urandom_range(1) ? ils_pkg::REQ_APPEND : ils_pkg::REQ_INSERT;
            else if (pick < grow_pct + shrink_pct)
                op = ils_pkg::REQ_REMOVE;
            else if (pick < 96)
                op = $urandom_range(1) ? ils_pkg::REQ_READ : ils_pkg::REQ_REPLACE;
            else
                op = ils_pkg::REQ_W'($urandom_range(int'(REQ_UNKNOWN_FIRST),
                                                    int'(REQ_UNKNOWN_LAST)));
            if ($urandom_range(99) < 10)
                pos = $urandom_range(POS_MAX);
            else if (op == ils_pkg::REQ_INSERT)
                pos = $urandom_range(shadow_len);
            else if (shadow_len > 0)
                pos = $urandom_range(shadow_len - 1);
            else
                pos = 0;
            send_request(op, pos, $urandom);
        end
    endtask

    // Every request on an empty list except insert at zero and append is rejected.
    task automatic test_empty_list();
        send_request(ils_pkg::REQ_READ, 0, '0);
        send_request(ils_pkg::REQ_REMOVE, 0, '0);
        send_request(ils_pkg::REQ_REPLACE, 0, '1);
        send_request(ils_pkg::REQ_INSERT, 1, '1);
        send_request(REQ_UNKNOWN_FIRST, 0, '1);
        send_request(REQ_UNKNOWN_LAST, POS_MAX, '1);
    endtask

    // Each operation at least once, on a list of capacity three, including full-list rejections.
    task automatic test_basic_ops();
        wait_drained();
        write_capacity(3);
        send_request(ils_pkg::REQ_APPEND, POS_MAX, '1);
        send_request(ils_pkg::REQ_INSERT, 0, '0);
        send_request(ils_pkg::REQ_INSERT, 2, $urandom);
        send_request(ils_pkg::REQ_INSERT, 0, $urandom);
        send_request(ils_pkg::REQ_APPEND, 0, $urandom);
        send_request(ils_pkg::REQ_READ, 0, '0);
        send_request(ils_pkg::REQ_READ, 2, '0);
        send_request(ils_pkg::REQ_REPLACE, 1, $urandom);
        send_request(ils_pkg::REQ_READ, 1, '0);
        send_request(ils_pkg::REQ_REMOVE, 0, '0);
        send_request(ils_pkg::REQ_REMOVE, 1, '0);
        send_request(ils_pkg::REQ_READ, 1, '0);
    endtask

    // Capacity lowered under the current length: growth stops, the rest works.
    task automatic test_capacity_below_count();
        send_request(ils_pkg::REQ_APPEND, 0, $urandom);
        send_request(ils_pkg::REQ_APPEND, 0, $urandom);
        wait_drained();
        write_capacity(1);
        send_request(ils_pkg::REQ_APPEND, 0, $urandom);
        send_request(ils_pkg::REQ_INSERT, 0, $urandom);
        send_request(ils_pkg::REQ_READ, 2, '0);
        send_request(ils_pkg::REQ_REMOVE, 2, '0);
    endtask

    // A capacity above the storage depth saturates; fill the list to the top.
    task automatic test_fill_saturated();
        wait_drained();
        write_capacity(CAP_MAX);
        run_random_phase(120, 80, 8, 0);
    endtask

    task automatic test_drain_full_depth();
        wait_drained();
        write_capacity(ils_pkg::MAX_ENTRIES_DEF);
        run_random_phase(100, 10, 50, 3);
    endtask

    task automatic test_zero_capacity();
        wait_drained();
        write_capacity(0);
        run_random_phase(30, 40, 25, 0);
    endtask

    task automatic test_single_entry();
        wait_drained();
        write_capacity(1);
        run_random_phase(40, 40, 25, 0);
    endtask

    task automatic test_random_capacity();
        wait_drained();
        write_capacity($urandom_range(2, ils_pkg::MAX_ENTRIES_DEF - 1));
        run_random_phase(80, 50, 25, 0);
    endtask

    // Back-to-back beats with neither side idling.
    task automatic test_back_to_back();
        wait_drained();
        write_capacity(ils_pkg::MAX_ENTRIES_DEF);
        gap_pct = 0;
        run_random_phase(80, 45, 35, 0);
        wait_drained();
        gap_pct = 25;
    endtask

    // Receiver stalls at random; stall is sampled at the edge it applies to.
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < gap_pct);

    // Compares each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        ils_pkg::t_out_beat want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (predicted_replies.size() == 0) begin
                $error("result beat with no request outstanding: %p", o_out_data);
                mismatch_count++;
            end else begin
                want = predicted_replies.pop_front();
                if (o_out_data.value_out !== want.value_out) begin
                    $error("value_out mismatch: expected %h, got %h",
                           want.value_out, o_out_data.value_out);
                    mismatch_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status mismatch: expected %b, got %b",
                           want.status, o_out_data.status);
                    mismatch_count++;
                end
                if (o_out_data.count !== want.count) begin
                    $error("count mismatch: expected %0d, got %0d",
                           want.count, o_out_data.count);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if no channel moves a beat for too long.
    initial begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0) ||
                (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        gap_pct        = 25;
        shadow_len     = 0;
        shadow_cap     = int'(ils_pkg::CAP_RESET);
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in_data      <= '0;
        i_out_stall    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        test_capacity_below_count();
        test_fill_saturated();
        test_drain_full_depth();
        test_zero_capacity();
        test_single_entry();
        test_random_capacity();
        test_back_to_back();

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
